[hw/rtl/tube_box_overlap_test_core_assert.svh]
// assertion macros shared by the tube/box overlap core
`ifndef TUBE_BOX_OVERLAP_TEST_CORE_ASSERT_SVH
`define TUBE_BOX_OVERLAP_TEST_CORE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define TBOT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// cond must never be seen at a clock edge
`define TBOT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

[hw/rtl/tbot_pkg.sv]
// types, widths and register codes for the tube/box overlap core
package tbot_pkg;

	localparam int COORD_BITS = 16;
	localparam int NUM_STAGES = 7;

	// derived widths
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int MAG_BITS  = 2 * COORD_BITS + 2;
	localparam int HALF_BITS = MAG_BITS / 2;
	localparam int SQ_BITS   = 2 * MAG_BITS;
	localparam int SUM_BITS  = SQ_BITS + 2;
	localparam int RAD2_BITS = 2 * COORD_BITS;
	localparam int DLEN_BITS = 2 * COORD_BITS + 2;
	localparam int RHS_BITS  = RAD2_BITS + DLEN_BITS;
	localparam int PP_BITS   = 2 * HALF_BITS;
	localparam int RPP_BITS  = RAD2_BITS + HALF_BITS;

	// configuration register codes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BEGIN_X     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BEGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BEGIN_Z     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_X       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_Y       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_Z       = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_TUBE_RADIUS = 3'd6;

	// reset values: unit axis along x, unit radius
	localparam logic [COORD_BITS-1:0] END_X_RESET  = COORD_BITS'(256);
	localparam logic [COORD_BITS-1:0] RADIUS_RESET = COORD_BITS'(256);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	// results of the cross product section
	typedef struct packed {
		logic [11:0][MAG_BITS-1:0] mag;
		logic [DLEN_BITS-1:0]      dlen2;
		logic [RAD2_BITS-1:0]      rad2;
		logic                      inbox;
	} cross_t;

	// results of the squaring section
	typedef struct packed {
		logic [11:0][SQ_BITS-1:0] sq;
		logic [RHS_BITS-1:0]      rhs;
		logic                     nz;
		logic                     inbox;
	} sq_t;

	// magnitude of the difference of two cross product terms
	function automatic logic [MAG_BITS-1:0] cross_mag(prod_t a, prod_t b);
		logic signed [PROD_BITS:0] t;
		t = (PROD_BITS + 1)'(a) - (PROD_BITS + 1)'(b);
		return MAG_BITS'(t[PROD_BITS] ? -t : t);
	endfunction

endpackage

[hw/rtl/tbot_cross.sv]
// stages 1-3: offsets, cross product terms, cross magnitudes and axis length
module tbot_cross (
	input  logic                                clk,
	input  logic [2:0]                          en,
	input  tbot_pkg::coord_t                    box_lo [3],
	input  tbot_pkg::coord_t                    box_hi [3],
	input  tbot_pkg::coord_t                    beg [3],
	input  tbot_pkg::coord_t                    fin [3],
	input  logic [tbot_pkg::COORD_BITS-1:0]     rad,
	output tbot_pkg::cross_t                    cross_s3
);

	tbot_pkg::diff_t p_lo [3];
	tbot_pkg::diff_t p_hi [3];
	tbot_pkg::diff_t d_c [3];
	logic beg_in;
	logic fin_in;

	tbot_pkg::diff_t p_s1 [3][2];
	tbot_pkg::diff_t d_s1 [3];
	logic [tbot_pkg::COORD_BITS-1:0] rad_s1;
	logic inbox_s1;

	tbot_pkg::prod_t prod_c [6][2];
	logic [tbot_pkg::RAD2_BITS-1:0] dsq_c [3];
	tbot_pkg::prod_t dsq_full [3];

	tbot_pkg::prod_t prod_s2 [6][2];
	logic [tbot_pkg::RAD2_BITS-1:0] dsq_s2 [3];
	logic [tbot_pkg::RAD2_BITS-1:0] rad2_s2;
	logic inbox_s2;

	// stage 1: corner offsets from begin, axis direction, begin and end point containment
	always_comb begin
		beg_in = 1'b1;
		fin_in = 1'b1;
		for (int i = 0; i < 3; i++) begin
			p_lo[i] = tbot_pkg::DIFF_BITS'(box_lo[i]) - tbot_pkg::DIFF_BITS'(beg[i]);
			p_hi[i] = tbot_pkg::DIFF_BITS'(box_hi[i]) - tbot_pkg::DIFF_BITS'(beg[i]);
			d_c[i]  = tbot_pkg::DIFF_BITS'(fin[i]) - tbot_pkg::DIFF_BITS'(beg[i]);
			if (beg[i] < box_lo[i] || beg[i] > box_hi[i]) begin
				beg_in = 1'b0;
			end
			if (fin[i] < box_lo[i] || fin[i] > box_hi[i]) begin
				fin_in = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i][0] <= p_lo[i];
				p_s1[i][1] <= p_hi[i];
				d_s1[i]    <= d_c[i];
			end
			rad_s1   <= rad;
			inbox_s1 <= beg_in | fin_in;
		end
	end

	// stage 2: the twelve distinct cross product terms and the axis squares
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			prod_c[0][s] = tbot_pkg::PROD_BITS'(d_s1[1]) * tbot_pkg::PROD_BITS'(p_s1[2][s]);
			prod_c[1][s] = tbot_pkg::PROD_BITS'(d_s1[2]) * tbot_pkg::PROD_BITS'(p_s1[1][s]);
			prod_c[2][s] = tbot_pkg::PROD_BITS'(d_s1[2]) * tbot_pkg::PROD_BITS'(p_s1[0][s]);
			prod_c[3][s] = tbot_pkg::PROD_BITS'(d_s1[0]) * tbot_pkg::PROD_BITS'(p_s1[2][s]);
			prod_c[4][s] = tbot_pkg::PROD_BITS'(d_s1[0]) * tbot_pkg::PROD_BITS'(p_s1[1][s]);
			prod_c[5][s] = tbot_pkg::PROD_BITS'(d_s1[1]) * tbot_pkg::PROD_BITS'(p_s1[0][s]);
		end
		for (int i = 0; i < 3; i++) begin
			dsq_full[i] = tbot_pkg::PROD_BITS'(d_s1[i]) * tbot_pkg::PROD_BITS'(d_s1[i]);
			dsq_c[i]    = dsq_full[i][tbot_pkg::RAD2_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2  <= prod_c;
			dsq_s2   <= dsq_c;
			rad2_s2  <= tbot_pkg::RAD2_BITS'(rad_s1) * tbot_pkg::RAD2_BITS'(rad_s1);
			inbox_s2 <= inbox_s1;
		end
	end

	// stage 3: cross component magnitudes, four corner pairs per component
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 4; j++) begin
				// x component depends on (y, z) choice
				cross_s3.mag[j]     <= tbot_pkg::cross_mag(prod_s2[0][j[0]], prod_s2[1][j[1]]);
				// y component depends on (x, z) choice
				cross_s3.mag[4 + j] <= tbot_pkg::cross_mag(prod_s2[2][j[1]], prod_s2[3][j[0]]);
				// z component depends on (x, y) choice
				cross_s3.mag[8 + j] <= tbot_pkg::cross_mag(prod_s2[4][j[0]], prod_s2[5][j[1]]);
			end
			cross_s3.dlen2 <= tbot_pkg::DLEN_BITS'(dsq_s2[0]) + tbot_pkg::DLEN_BITS'(dsq_s2[1])
				+ tbot_pkg::DLEN_BITS'(dsq_s2[2]);
			cross_s3.rad2  <= rad2_s2;
			cross_s3.inbox <= inbox_s2;
		end
	end

endmodule

[hw/rtl/tbot_square.sv]
// stages 4-5: squares of the cross magnitudes and radius times axis length
module tbot_square (
	input  logic             clk,
	input  logic [1:0]       en,
	input  tbot_pkg::cross_t cross_s3,
	output tbot_pkg::sq_t    sq_s5
);

	localparam int H = tbot_pkg::HALF_BITS;

	logic [11:0][tbot_pkg::PP_BITS-1:0] pp_ll_s4;
	logic [11:0][tbot_pkg::PP_BITS-1:0] pp_lh_s4;
	logic [11:0][tbot_pkg::PP_BITS-1:0] pp_hh_s4;
	logic [tbot_pkg::RPP_BITS-1:0] rhs_lo_s4;
	logic [tbot_pkg::RPP_BITS-1:0] rhs_hi_s4;
	logic nz_s4;
	logic inbox_s4;

	// stage 4: half-width partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 12; j++) begin
				pp_ll_s4[j] <= tbot_pkg::PP_BITS'(cross_s3.mag[j][H-1:0])
					* tbot_pkg::PP_BITS'(cross_s3.mag[j][H-1:0]);
				pp_lh_s4[j] <= tbot_pkg::PP_BITS'(cross_s3.mag[j][H-1:0])
					* tbot_pkg::PP_BITS'(cross_s3.mag[j][tbot_pkg::MAG_BITS-1:H]);
				pp_hh_s4[j] <= tbot_pkg::PP_BITS'(cross_s3.mag[j][tbot_pkg::MAG_BITS-1:H])
					* tbot_pkg::PP_BITS'(cross_s3.mag[j][tbot_pkg::MAG_BITS-1:H]);
			end
			rhs_lo_s4 <= tbot_pkg::RPP_BITS'(cross_s3.rad2)
				* tbot_pkg::RPP_BITS'(cross_s3.dlen2[H-1:0]);
			rhs_hi_s4 <= tbot_pkg::RPP_BITS'(cross_s3.rad2)
				* tbot_pkg::RPP_BITS'(cross_s3.dlen2[tbot_pkg::DLEN_BITS-1:H]);
			nz_s4     <= (cross_s3.dlen2 != '0);
			inbox_s4  <= cross_s3.inbox;
		end
	end

	// stage 5: recombine partial products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 12; j++) begin
				sq_s5.sq[j] <= (tbot_pkg::SQ_BITS'(pp_hh_s4[j]) << (2 * H))
					+ (tbot_pkg::SQ_BITS'(pp_lh_s4[j]) << (H + 1))
					+ tbot_pkg::SQ_BITS'(pp_ll_s4[j]);
			end
			sq_s5.rhs   <= (tbot_pkg::RHS_BITS'(rhs_hi_s4) << H) + tbot_pkg::RHS_BITS'(rhs_lo_s4);
			sq_s5.nz    <= nz_s4;
			sq_s5.inbox <= inbox_s4;
		end
	end

endmodule

[hw/rtl/tbot_decide.sv]
// stages 6-7: per-corner squared distance sums and the final hit decision
module tbot_decide (
	input  logic          clk,
	input  logic [1:0]    en,
	input  tbot_pkg::sq_t sq_s5,
	output logic          hit_s7
);

	logic [7:0][tbot_pkg::SUM_BITS-1:0] sum_s6;
	logic [tbot_pkg::RHS_BITS-1:0] rhs_s6;
	logic nz_s6;
	logic inbox_s6;
	logic [7:0] le;

	// stage 6: corner k picks x by bit 2, y by bit 1, z by bit 0
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 8; k++) begin
				sum_s6[k] <= tbot_pkg::SUM_BITS'(sq_s5.sq[k & 3])
					+ tbot_pkg::SUM_BITS'(sq_s5.sq[4 + ((k >> 1) & 2) + (k & 1)])
					+ tbot_pkg::SUM_BITS'(sq_s5.sq[8 + (k >> 1)]);
			end
			rhs_s6   <= sq_s5.rhs;
			nz_s6    <= sq_s5.nz;
			inbox_s6 <= sq_s5.inbox;
		end
	end

	// stage 7: compare against radius squared times axis length squared
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			le[k] = (sum_s6[k] <= tbot_pkg::SUM_BITS'(rhs_s6));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit_s7 <= inbox_s6 | (nz_s6 & (|le));
		end
	end

endmodule

[hw/rtl/tube_box_overlap_test_core.sv]
// tube_box_overlap_test_core: infinite tube versus axis-aligned box overlap test
// Usage:
//  - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the axis begin and
//    end points and the tube radius; cfg_ready is always high, unknown indexes are
//    dropped; write only while no box is in flight
//  - input channel takes one box (min and max corners) per transfer; the axis and radius
//    in force at that transfer are the ones used for that box
//  - output channel gives one hit bit per box, in order
//  - pipeline: the input transfer itself loads the first of seven register stages and
//    out_valid rises once the box reaches the last; one box per cycle while out_ready
//    stays high (offsets, cross terms, magnitudes, split squares, sums, compare)
//  - reset clears all stage valids and loads begin (0,0,0), end (1.0,0,0), radius 1.0
//  - when the receiver stalls, the last stage holds its result and empty stages
//    upstream keep filling; in_ready drops only once every stage holds a box
module tube_box_overlap_test_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tbot_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [tbot_pkg::COORD_BITS-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_min_x,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_min_y,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_min_z,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_max_x,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_max_y,
	input  logic signed [tbot_pkg::COORD_BITS-1:0] box_max_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit
);

`include "tube_box_overlap_test_core_assert.svh"

	localparam int NS = tbot_pkg::NUM_STAGES;

	tbot_pkg::coord_t beg_q [3];
	tbot_pkg::coord_t fin_q [3];
	logic [tbot_pkg::COORD_BITS-1:0] rad_q;

	tbot_pkg::coord_t box_lo [3];
	tbot_pkg::coord_t box_hi [3];

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	tbot_pkg::cross_t cross_s3;
	tbot_pkg::sq_t    sq_s5;
	logic             hit_s7;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beg_q[0] <= '0;
			beg_q[1] <= '0;
			beg_q[2] <= '0;
			fin_q[0] <= tbot_pkg::END_X_RESET;
			fin_q[1] <= '0;
			fin_q[2] <= '0;
			rad_q    <= tbot_pkg::RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tbot_pkg::REG_BEGIN_X:     beg_q[0] <= cfg_data;
				tbot_pkg::REG_BEGIN_Y:     beg_q[1] <= cfg_data;
				tbot_pkg::REG_BEGIN_Z:     beg_q[2] <= cfg_data;
				tbot_pkg::REG_END_X:       fin_q[0] <= cfg_data;
				tbot_pkg::REG_END_Y:       fin_q[1] <= cfg_data;
				tbot_pkg::REG_END_Z:       fin_q[2] <= cfg_data;
				tbot_pkg::REG_TUBE_RADIUS: rad_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// box corners as arrays
	assign box_lo[0] = box_min_x;
	assign box_lo[1] = box_min_y;
	assign box_lo[2] = box_min_z;
	assign box_hi[0] = box_max_x;
	assign box_hi[1] = box_max_y;
	assign box_hi[2] = box_max_z;

	// stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NS-1];
	assign hit       = hit_s7;

	// datapath sections
	tbot_cross u_cross (
		.clk      (clk),
		.en       (en[2:0]),
		.box_lo   (box_lo),
		.box_hi   (box_hi),
		.beg      (beg_q),
		.fin      (fin_q),
		.rad      (rad_q),
		.cross_s3 (cross_s3)
	);

	tbot_square u_square (
		.clk      (clk),
		.en       (en[4:3]),
		.cross_s3 (cross_s3),
		.sq_s5    (sq_s5)
	);

	tbot_decide u_decide (
		.clk    (clk),
		.en     (en[6:5]),
		.sq_s5  (sq_s5),
		.hit_s7 (hit_s7)
	);

	// checks
	`TBOT_ASSERT_IMPLY(a_ready_follows_out, clk, arst_n, out_ready, in_ready)
	`TBOT_ASSERT_NEVER(a_full_stall_blocks, clk, arst_n, (&vld_q) && !out_ready && in_ready)
	`TBOT_ASSERT_IMPLY(a_out_from_stage6, clk, arst_n, $rose(out_valid), $past(vld_q[NS-2]))

endmodule
